// ===== rtl/cleb_pkg.sv =====
`default_nettype none

package cleb_pkg;

    // Action codes carried by the input transaction.
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LEFT   = 2'd1;
    localparam logic [1:0] ACT_RIGHT  = 2'd2;
    localparam logic [1:0] ACT_FLUSH  = 2'd3;

    // Depth of the command queue between the front and the back.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_LEFT,
        OP_RIGHT,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] in_char;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
        logic       empty_line;
        logic       dropped;
    } out_item_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } cmd_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_slot_t;

endpackage

`default_nettype wire

// ===== rtl/cursor_line_edit_buffer.sv =====
// Accepted actions queue in the front; the back end serves the queue head. An
// insert completes in idle, so inserts run one per cycle while it stays idle;
// a move passes ST_MOVE_L or ST_MOVE_R; a flush runs ST_FL_RD (registered read)
// and ST_FL_WR, which waits for a free output, per character; an empty line is
// registered at its pop. Reset (rst_n low, asynchronous) empties the queue, the
// counts, the drop flag and the output register; the stores are not cleared.
`default_nettype none

module cursor_line_edit_buffer #(
    parameter int LINE_DEPTH = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cleb_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cleb_pkg::out_item_t      out_data
);
    import cleb_pkg::*;

    cmd_slot_t head;
    logic      pop;

    cleb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .head     (head),
        .pop      (pop)
    );

    cleb_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/cleb_front.sv =====
`default_nettype none

module cleb_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cleb_pkg::in_item_t in_data,
    output cleb_pkg::cmd_slot_t     head,
    input  wire logic               pop
);
    import cleb_pkg::*;

    cmd_t              queue_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW:0]     count_reg;
    cmd_t              cmd_in;
    logic              push;
    logic              do_pop;

    // Classify the action and strip the character from moves and flushes.
    always_comb
    begin
        cmd_in.ch = 8'd0;
        case (in_data.action)
            ACT_INSERT:
            begin
                cmd_in.op = OP_INSERT;
                cmd_in.ch = in_data.in_char;
            end
            ACT_LEFT:  cmd_in.op = OP_LEFT;
            ACT_RIGHT: cmd_in.op = OP_RIGHT;
            ACT_FLUSH: cmd_in.op = OP_FLUSH;
            default:   cmd_in.op = OP_FLUSH;
        endcase
    end

    assign in_ready   = (count_reg != (Q_AW+1)'(Q_DEPTH));
    assign push       = in_valid && in_ready;
    assign head.valid = (count_reg != '0);
    assign head.cmd   = queue_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cleb_back.sv =====
`default_nettype none

module cleb_back #(
    parameter int LINE_DEPTH = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cleb_pkg::cmd_slot_t head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cleb_pkg::out_item_t      out_data
);
    import cleb_pkg::*;

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW = $clog2(LINE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE_L,
        ST_MOVE_R,
        ST_FL_RD,
        ST_FL_WR
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   bc_reg;
    logic [CW-1:0]   ac_reg;
    logic [CW-1:0]   n_reg;
    logic            drop_reg;
    logic            out_valid_reg;
    out_item_t       out_data_reg;

    logic [7:0]      bmem [LINE_DEPTH];
    logic [7:0]      amem [LINE_DEPTH];
    logic [7:0]      b_rdata_reg;
    logic [7:0]      a_rdata_reg;

    logic [CW-1:0]   total;
    logic [CW-1:0]   bc_dec;
    logic [CW-1:0]   ac_dec;
    logic [CW-1:0]   tail_idx;
    logic            full;
    logic            out_free;
    logic            out_load;
    logic            fl_last;
    logic            b_we;
    logic            a_we;
    logic [AW-1:0]   b_raddr;
    logic [AW-1:0]   a_raddr;
    logic [7:0]      b_wdata;

    assign total    = bc_reg + ac_reg;
    assign bc_dec   = bc_reg - CW'(1);
    assign ac_dec   = ac_reg - CW'(1);
    assign tail_idx = total - CW'(1) - n_reg;
    assign full     = (total >= CW'(LINE_DEPTH));
    assign out_free = !out_valid_reg || out_ready;
    assign fl_last  = (n_reg == total - CW'(1));

    // An empty-line flush produces its result at once, so it waits for the output.
    assign pop = (state_reg == ST_IDLE) && head.valid
                 && (head.cmd.op != OP_FLUSH || total != '0 || out_free);

    assign out_load = (pop && head.cmd.op == OP_FLUSH && total == '0)
                      || (state_reg == ST_FL_WR && out_free);

    // In idle the read ports look at the stack tops for a possible move;
    // during a flush they walk the line from its first character.
    assign b_raddr = (state_reg == ST_IDLE) ? bc_dec[AW-1:0] : n_reg[AW-1:0];
    assign a_raddr = (state_reg == ST_IDLE) ? ac_dec[AW-1:0] : tail_idx[AW-1:0];

    assign b_we    = (pop && head.cmd.op == OP_INSERT && !full) || (state_reg == ST_MOVE_R);
    assign b_wdata = (state_reg == ST_MOVE_R) ? a_rdata_reg : head.cmd.ch;
    assign a_we    = (state_reg == ST_MOVE_L);

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            bmem[bc_reg[AW-1:0]] <= b_wdata;
        end
        b_rdata_reg <= bmem[b_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            amem[ac_reg[AW-1:0]] <= b_rdata_reg;
        end
        a_rdata_reg <= amem[a_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bc_reg        <= '0;
            ac_reg        <= '0;
            n_reg         <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        case (head.cmd.op)
                            OP_INSERT:
                            begin
                                if (full)
                                begin
                                    drop_reg <= 1'b1;
                                end
                                else
                                begin
                                    bc_reg <= bc_reg + CW'(1);
                                end
                            end
                            OP_LEFT:
                            begin
                                if (bc_reg != '0)
                                begin
                                    state_reg <= ST_MOVE_L;
                                end
                            end
                            OP_RIGHT:
                            begin
                                if (ac_reg != '0)
                                begin
                                    state_reg <= ST_MOVE_R;
                                end
                            end
                            OP_FLUSH:
                            begin
                                if (total == '0)
                                begin
                                    out_data_reg.out_char   <= 8'd0;
                                    out_data_reg.last       <= 1'b1;
                                    out_data_reg.empty_line <= 1'b1;
                                    out_data_reg.dropped    <= drop_reg;
                                    drop_reg                <= 1'b0;
                                end
                                else
                                begin
                                    n_reg     <= '0;
                                    state_reg <= ST_FL_RD;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_MOVE_L:
                begin
                    bc_reg    <= bc_dec;
                    ac_reg    <= ac_reg + CW'(1);
                    state_reg <= ST_IDLE;
                end
                ST_MOVE_R:
                begin
                    ac_reg    <= ac_dec;
                    bc_reg    <= bc_reg + CW'(1);
                    state_reg <= ST_IDLE;
                end
                ST_FL_RD:
                begin
                    state_reg <= ST_FL_WR;
                end
                ST_FL_WR:
                begin
                    if (out_free)
                    begin
                        out_data_reg.out_char   <= (n_reg < bc_reg) ? b_rdata_reg : a_rdata_reg;
                        out_data_reg.last       <= fl_last;
                        out_data_reg.empty_line <= 1'b0;
                        out_data_reg.dropped    <= drop_reg;
                        if (fl_last)
                        begin
                            bc_reg    <= '0;
                            ac_reg    <= '0;
                            drop_reg  <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            n_reg     <= n_reg + CW'(1);
                            state_reg <= ST_FL_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/cleb_checker.sv =====
`default_nettype none

module cleb_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire cleb_pkg::out_item_t out_data
);
    import cleb_pkg::*;

    // A stalled result transaction keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // An empty line is always the final result of its flush.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.empty_line |-> out_data.last)
        else $error("empty line without last marker");

    // An empty line carries no character.
    a_empty_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.empty_line |-> out_data.out_char == 8'd0)
        else $error("empty line with a character");

    // Nothing is offered right out of reset.
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule

bind cursor_line_edit_buffer cleb_checker u_cleb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== bench/cursor_line_edit_buffer_tb.sv =====
`default_nettype none

module cursor_line_edit_buffer_tb;

    import cleb_pkg::*;

    localparam int TB_DEPTH    = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_GOAL = 45;

    localparam out_item_t EMPTY_FLUSH = '{8'h00, 1'b1, 1'b1, 1'b0};
    localparam out_item_t NO_RESULT   = '{8'h00, 1'b0, 1'b0, 1'b0};

    typedef struct {
        logic [1:0] act;
        logic [7:0] ch;
        int         reps;
        bit         pinned;
        out_item_t  want;
    } edit_step_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    // Shadow of the line: characters left of the cursor and right of it.
    logic [7:0] left_stack[TB_DEPTH];
    logic [7:0] right_stack[TB_DEPTH];
    int         left_len = 0;
    int         right_len = 0;
    bit         overflow_seen = 1'b0;

    out_item_t  line_out_q[$];
    out_item_t  want_item;
    bit         pin_on;
    out_item_t  pin_item;
    bit         calm;

    int errors = 0;
    int cycles = 0;
    int items_in = 0;
    int edits_done = 0;
    int flushes_done = 0;
    int chars_seen = 0;
    int drops_done = 0;

    edit_step_t opening_steps[19] = '{
        '{ACT_FLUSH,  8'h00, 1,  1'b1, EMPTY_FLUSH},
        '{ACT_LEFT,   8'h00, 1,  1'b0, NO_RESULT},
        '{ACT_RIGHT,  8'hFF, 1,  1'b0, NO_RESULT},
        '{ACT_INSERT, 8'h00, 1,  1'b0, NO_RESULT},
        '{ACT_INSERT, 8'hFF, 1,  1'b0, NO_RESULT},
        '{ACT_INSERT, 8'h3C, 1,  1'b0, NO_RESULT},
        '{ACT_INSERT, 8'h3E, 1,  1'b0, NO_RESULT},
        '{ACT_LEFT,   8'h3C, 2,  1'b0, NO_RESULT},
        '{ACT_INSERT, 8'hA5, 1,  1'b0, NO_RESULT},
        '{ACT_RIGHT,  8'h3E, 3,  1'b0, NO_RESULT},
        '{ACT_FLUSH,  8'hFF, 1,  1'b0, NO_RESULT},
        '{ACT_INSERT, 8'h5A, 1,  1'b0, NO_RESULT},
        '{ACT_FLUSH,  8'h00, 1,  1'b1, '{8'h5A, 1'b1, 1'b0, 1'b0}},
        '{ACT_INSERT, 8'h30, 65, 1'b0, NO_RESULT},
        '{ACT_LEFT,   8'h00, 65, 1'b0, NO_RESULT},
        '{ACT_INSERT, 8'h7F, 1,  1'b0, NO_RESULT},
        '{ACT_RIGHT,  8'h00, 10, 1'b0, NO_RESULT},
        '{ACT_FLUSH,  8'h00, 1,  1'b0, NO_RESULT},
        '{ACT_FLUSH,  8'h00, 1,  1'b1, EMPTY_FLUSH}
    };

    cursor_line_edit_buffer #(
        .LINE_DEPTH(TB_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always #4 clk = ~clk;

    // Applies one edit to the shadow line and queues the characters it sends out.
    // Returns 0 for a cursor move that runs into either end of the line.
    function automatic bit apply_edit(input in_item_t item, input bit queue_line);
        out_item_t res;
        int        total;
        int        i;
        bit        took;
        took = 1'b1;
        case (item.action)
            ACT_INSERT:
            begin
                if (left_len + right_len >= TB_DEPTH)
                begin
                    overflow_seen = 1'b1;
                    drops_done++;
                end
                else
                begin
                    left_stack[left_len] = item.in_char;
                    left_len++;
                end
            end
            ACT_LEFT:
            begin
                if (left_len > 0)
                begin
                    left_len--;
                    right_stack[right_len] = left_stack[left_len];
                    right_len++;
                end
                else
                begin
                    took = 1'b0;
                end
            end
            ACT_RIGHT:
            begin
                if (right_len > 0)
                begin
                    right_len--;
                    left_stack[left_len] = right_stack[right_len];
                    left_len++;
                end
                else
                begin
                    took = 1'b0;
                end
            end
            default:
            begin
                total = left_len + right_len;
                res.dropped = overflow_seen;
                res.empty_line = (total == 0);
                if (total == 0)
                begin
                    res.out_char = 8'h00;
                    res.last = 1'b1;
                    if (queue_line) line_out_q.push_back(res);
                end
                for (i = 0; i < total; i++)
                begin
                    res.out_char = (i < left_len) ? left_stack[i]
                                                  : right_stack[total - 1 - i];
                    res.last = (i == total - 1);
                    if (queue_line) line_out_q.push_back(res);
                end
                flushes_done++;
                left_len = 0;
                right_len = 0;
                overflow_seen = 1'b0;
            end
        endcase
        return took;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                chars_seen++;
                if (line_out_q.size() == 0)
                begin
                    $error("unexpected output transaction: %p", out_data);
                    errors++;
                end
                else
                begin
                    want_item = line_out_q.pop_front();
                    if (out_data.out_char !== want_item.out_char)
                    begin
                        $error("out_char: expected %02h, got %02h",
                               want_item.out_char, out_data.out_char);
                        errors++;
                    end
                    if (out_data.last !== want_item.last)
                    begin
                        $error("last: expected %0b, got %0b", want_item.last, out_data.last);
                        errors++;
                    end
                    if (out_data.empty_line !== want_item.empty_line)
                    begin
                        $error("empty_line: expected %0b, got %0b",
                               want_item.empty_line, out_data.empty_line);
                        errors++;
                    end
                    if (out_data.dropped !== want_item.dropped)
                    begin
                        $error("dropped: expected %0b, got %0b",
                               want_item.dropped, out_data.dropped);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                items_in++;
                if (pin_on) line_out_q.push_back(pin_item);
                if (apply_edit(in_data, !pin_on)) edits_done++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycles);
            $display("cursor_line_edit_buffer_tb: FAIL");
            $finish;
        end
    end

    // Receiver side: random stalls until the calm stretch at the end.
    initial
    begin
        int hold;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                hold = $urandom_range(1, 13);
            end
            else
            begin
                out_ready <= 1'b1;
                hold = $urandom_range(1, 24);
            end
            repeat (hold) @(negedge clk);
        end
    end

    task automatic send_edit(input logic [1:0] act, input logic [7:0] ch,
                             input bit pinned, input out_item_t want);
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{action: act, in_char: ch};
        pin_on   = pinned;
        pin_item = want;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_line(input bit long_line, input bit with_flush);
        int n_edits;
        int i;
        int pick;
        logic [1:0] act;
        n_edits = long_line ? $urandom_range(60, 72) : $urandom_range(0, 12);
        for (i = 0; i < n_edits; i++)
        begin
            pick = $urandom_range(0, 9);
            if (long_line) act = (pick < 9) ? ACT_INSERT : ((pick[0]) ? ACT_LEFT : ACT_RIGHT);
            else if (pick < 5) act = ACT_INSERT;
            else if (pick < 7) act = ACT_LEFT;
            else act = ACT_RIGHT;
            send_edit(act, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
        end
        if (with_flush) send_edit(ACT_FLUSH, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
    endtask

    initial
    begin
        int s;
        int k;
        int start_items;
        int pick;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        pin_on = 1'b0;
        pin_item = NO_RESULT;
        calm = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (s = 0; s < $size(opening_steps); s++)
        begin
            for (k = 0; k < opening_steps[s].reps; k++)
            begin
                send_edit(opening_steps[s].act, opening_steps[s].ch + 8'(k),
                          opening_steps[s].pinned, opening_steps[s].want);
            end
        end

        // Hold the input side off until every expected result has come out.
        @(negedge clk);
        in_valid <= 1'b0;
        while (line_out_q.size() != 0) @(negedge clk);

        start_items = items_in;
        while (items_in - start_items < RANDOM_GOAL)
        begin
            calm = (items_in - start_items >= RANDOM_GOAL * 3 / 4);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                send_edit(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'b0, NO_RESULT);
            end
            else if (pick == 1)
            begin
                send_line(1'b0, 1'b0);
            end
            else
            begin
                send_line($urandom_range(0, 7) == 0, 1'b1);
            end
        end
        calm = 1'b1;
        send_edit(ACT_FLUSH, 8'h00, 1'b0, NO_RESULT);

        @(negedge clk);
        in_valid <= 1'b0;
        pin_on = 1'b0;
        while (line_out_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("edits applied: %0d, lines flushed: %0d, characters returned: %0d",
                 edits_done, flushes_done, chars_seen);
        $display("inserts lost to a full line: %0d, mismatches: %0d", drops_done, errors);
        if (errors == 0)
        begin
            $display("cursor_line_edit_buffer_tb: PASS");
        end
        else
        begin
            $display("cursor_line_edit_buffer_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
